FILE: rtl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and constants of the bitmap shape rasterizer.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int CANVAS_COLS = 64;
  localparam int CANVAS_ROWS = 32;
  localparam int ROW_AW      = 5;
  localparam int COORD_W     = 14;
  localparam int DEC_W       = 16;

  typedef enum logic [2:0] {
    REQ_CLEAR  = 3'd0,
    REQ_LINE   = 3'd1,
    REQ_RECT   = 3'd2,
    REQ_CIRCLE = 3'd3,
    REQ_TRI    = 3'd4,
    REQ_READ   = 3'd5
  } req_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;       // capture the request fields
    logic       line_load;   // load a line segment
    logic [1:0] seg;         // which segment to load
    logic       line_step;   // plot one line pixel and advance
    logic       circ_load;
    logic       circ_step;   // plot one octant point (one of eight)
    logic       clr_step;    // blank one row
    logic       clr_load;
    logic       rd_load;     // read the selected row into the output
  } bsr_cmd_t;

  typedef struct packed {
    logic line_done;   // the current line pixel is the last
    logic circ_done;   // current octant loop index finished
    logic clr_done;
    logic [2:0] req;
  } bsr_sts_t;

endpackage

FILE: rtl/bitmap_shape_rasterizer.sv
// ----------------------------------------------------------------------------
// bitmap_shape_rasterizer
// One-bit canvas of 32 rows by 64 columns with line, rectangle, triangle,
// circle, clear and row read commands.
// ----------------------------------------------------------------------------
// One command is worked at a time. A line plots one pixel per cycle and
// loads each segment before walking it; rectangles have four segments and
// triangles three. A circle plots one of its eight symmetric points per
// cycle. Clear walks the 32 rows. Read and unused codes go from dispatch
// straight to the result. Each command returns exactly one result word;
// row_bits is nonzero only for a read.
module bitmap_shape_rasterizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         req_type,
  input  logic signed [11:0] ax,
  input  logic signed [11:0] ay,
  input  logic signed [11:0] bx,
  input  logic signed [11:0] by,
  input  logic signed [11:0] cx,
  input  logic signed [11:0] cy,
  input  logic signed [11:0] rect_width,
  input  logic signed [11:0] rect_height,
  input  logic [10:0]        radius,
  input  logic [4:0]         row_select,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        row_bits,
  output logic               is_readback
);

  bsr_pkg::bsr_cmd_t cmd;
  bsr_pkg::bsr_sts_t sts;

  bsr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  bsr_dp u_dp (
    .clk, .rst, .cmd, .sts, .req_type, .ax, .ay, .bx, .by, .cx, .cy,
    .rect_width, .rect_height, .radius, .row_select, .row_bits, .is_readback
  );

endmodule

FILE: rtl/bsr_ctrl.sv
// ----------------------------------------------------------------------------
// bsr_ctrl
// Command sequencer of the rasterizer.
// ----------------------------------------------------------------------------
module bsr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bsr_pkg::bsr_sts_t sts,
  output bsr_pkg::bsr_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DISP  = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_LINE  = 7'b0001000,
    S_CIRC  = 7'b0010000,
    S_CLR   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] seg, seg_next;
  logic [1:0] nseg;

  always_comb begin
    case (sts.req)
      bsr_pkg::REQ_RECT: nseg = 2'd3;
      bsr_pkg::REQ_TRI:  nseg = 2'd2;
      default:           nseg = 2'd0;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    seg_next   = seg;
    cmd        = '0;
    cmd.seg    = seg;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        seg_next = 2'd0;
        case (sts.req)
          bsr_pkg::REQ_CLEAR: begin
            cmd.clr_load = 1'b1;
            state_next   = S_CLR;
          end
          bsr_pkg::REQ_LINE, bsr_pkg::REQ_RECT, bsr_pkg::REQ_TRI: begin
            state_next = S_LOAD;
          end
          bsr_pkg::REQ_CIRCLE: begin
            cmd.circ_load = 1'b1;
            state_next    = S_CIRC;
          end
          default: begin
            cmd.rd_load = 1'b1;
            state_next  = S_OUT;
          end
        endcase
      end
      S_LOAD: begin
        cmd.line_load = 1'b1;
        state_next    = S_LINE;
      end
      S_LINE: begin
        cmd.line_step = 1'b1;
        if (sts.line_done) begin
          if (seg == nseg) begin
            cmd.rd_load = 1'b1;
            state_next  = S_OUT;
          end else begin
            seg_next   = seg + 2'd1;
            state_next = S_LOAD;
          end
        end
      end
      S_CIRC: begin
        cmd.circ_step = 1'b1;
        if (sts.circ_done) begin
          cmd.rd_load = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          cmd.rd_load = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seg   <= 2'd0;
    end else begin
      state <= state_next;
      seg   <= seg_next;
    end
  end

`ifndef SYNTH
  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_out_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
`endif

endmodule

FILE: rtl/bsr_dp.sv
// ----------------------------------------------------------------------------
// bsr_dp
// Line and circle steppers, canvas store and result register.
// ----------------------------------------------------------------------------
module bsr_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  bsr_pkg::bsr_cmd_t        cmd,
  output bsr_pkg::bsr_sts_t        sts,
  input  logic [2:0]               req_type,
  input  logic signed [11:0]       ax,
  input  logic signed [11:0]       ay,
  input  logic signed [11:0]       bx,
  input  logic signed [11:0]       by,
  input  logic signed [11:0]       cx,
  input  logic signed [11:0]       cy,
  input  logic signed [11:0]       rect_width,
  input  logic signed [11:0]       rect_height,
  input  logic [10:0]              radius,
  input  logic [4:0]               row_select,
  output logic [63:0]              row_bits,
  output logic                     is_readback
);

  typedef logic signed [bsr_pkg::COORD_W-1:0] crd_t;
  typedef logic signed [bsr_pkg::DEC_W-1:0]   dec_t;

  logic [2:0] req;
  crd_t       pax, pay, pbx, pby, pcx, pcy, pex, pey;
  logic [10:0] rad;
  logic [4:0]  sel;

  // Canvas rows with a valid bit per row; an invalid row reads as blank.
  logic [63:0] canvas [bsr_pkg::CANVAS_ROWS];
  logic [bsr_pkg::CANVAS_ROWS-1:0] row_ok;

  // Line stepper.
  crd_t x0, y0, x1, y1, ldx, ldy;
  dec_t err;
  logic stx, sty;
  // Circle stepper.
  crd_t cxc, cyc, px, py;
  dec_t d;
  logic [2:0] oct;
  logic [4:0] clr_row;

  crd_t s0x, s0y, s1x, s1y;
  always_comb begin
    case (cmd.seg)
      2'd0: begin
        s0x = pax; s0y = pay;
        s1x = (req == bsr_pkg::REQ_RECT) ? pex : pbx;
        s1y = (req == bsr_pkg::REQ_RECT) ? pay : pby;
      end
      2'd1: begin
        s0x = (req == bsr_pkg::REQ_RECT) ? pax : pbx;
        s0y = (req == bsr_pkg::REQ_RECT) ? pay : pby;
        s1x = (req == bsr_pkg::REQ_RECT) ? pax : pcx;
        s1y = (req == bsr_pkg::REQ_RECT) ? pey : pcy;
      end
      2'd2: begin
        s0x = (req == bsr_pkg::REQ_RECT) ? pex : pcx;
        s0y = (req == bsr_pkg::REQ_RECT) ? pay : pcy;
        s1x = (req == bsr_pkg::REQ_RECT) ? pex : pax;
        s1y = (req == bsr_pkg::REQ_RECT) ? pey : pay;
      end
      default: begin
        s0x = pax; s0y = pey; s1x = pex; s1y = pey;
      end
    endcase
  end

  crd_t ndx, ndy;
  assign ndx = (s1x > s0x) ? s1x - s0x : s0x - s1x;
  assign ndy = (s1y > s0y) ? s1y - s0y : s0y - s1y;

  dec_t e2;
  logic stepx, stepy;
  assign e2    = err <<< 1;
  assign stepx = e2 > -dec_t'(ldy);
  assign stepy = e2 < dec_t'(ldx);
  assign sts.line_done = (x0 == x1) && (y0 == y1);
  assign sts.circ_done = (oct == 3'd7) &&
                         !((d > 0) ? (py - crd_t'(1) >= px + crd_t'(1)) :
                                     (py >= px + crd_t'(1)));
  assign sts.clr_done  = (clr_row == 5'(bsr_pkg::CANVAS_ROWS - 1));
  assign sts.req       = req;

  // Point of the current octant.
  crd_t ox, oy, plx, ply;
  always_comb begin
    case (oct)
      3'd0: begin ox = px;  oy = py;  end
      3'd1: begin ox = -px; oy = py;  end
      3'd2: begin ox = px;  oy = -py; end
      3'd3: begin ox = -px; oy = -py; end
      3'd4: begin ox = py;  oy = px;  end
      3'd5: begin ox = -py; oy = px;  end
      3'd6: begin ox = py;  oy = -px; end
      default: begin ox = -py; oy = -px; end
    endcase
    plx = cmd.circ_step ? cxc + ox : x0;
    ply = cmd.circ_step ? cyc + oy : y0;
  end

  logic plot_en;
  assign plot_en = (cmd.line_step || cmd.circ_step) && plx >= 0 &&
                   plx < crd_t'(bsr_pkg::CANVAS_COLS) && ply >= 0 &&
                   ply < crd_t'(bsr_pkg::CANVAS_ROWS);

  logic [4:0] prow;
  assign prow = ply[4:0];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= req_type;
      pax <= crd_t'(ax); pay <= crd_t'(ay);
      pbx <= crd_t'(bx); pby <= crd_t'(by);
      pcx <= crd_t'(cx); pcy <= crd_t'(cy);
      pex <= crd_t'(ax) + crd_t'(rect_width);
      pey <= crd_t'(ay) + crd_t'(rect_height);
      rad <= radius;
      sel <= row_select;
    end
    if (cmd.line_load) begin
      x0 <= s0x; y0 <= s0y; x1 <= s1x; y1 <= s1y;
      ldx <= ndx; ldy <= ndy;
      err <= dec_t'(ndx) - dec_t'(ndy);
      stx <= s0x < s1x; sty <= s0y < s1y;
    end else if (cmd.line_step) begin
      err <= err - (stepx ? dec_t'(ldy) : '0) + (stepy ? dec_t'(ldx) : '0);
      if (stepx) x0 <= stx ? x0 + crd_t'(1) : x0 - crd_t'(1);
      if (stepy) y0 <= sty ? y0 + crd_t'(1) : y0 - crd_t'(1);
    end
    if (cmd.circ_load) begin
      cxc <= pax; cyc <= pay; px <= '0; py <= crd_t'({1'b0, rad});
      d   <= dec_t'(3) - (dec_t'({1'b0, rad}) <<< 1);
      oct <= 3'd0;
    end else if (cmd.circ_step) begin
      oct <= oct + 3'd1;
      if (oct == 3'd7) begin
        px <= px + crd_t'(1);
        if (d > 0) begin
          py <= py - crd_t'(1);
          d  <= d + ((dec_t'(px) + dec_t'(1) - dec_t'(py) + dec_t'(1)) <<< 2) +
                dec_t'(10);
        end else begin
          d  <= d + ((dec_t'(px) + dec_t'(1)) <<< 2) + dec_t'(6);
        end
      end
    end
    if (cmd.clr_load) clr_row <= 5'd0;
    else if (cmd.clr_step) clr_row <= clr_row + 5'd1;
    if (cmd.rd_load) begin
      is_readback <= (req == bsr_pkg::REQ_READ);
      row_bits    <= (req == bsr_pkg::REQ_READ && row_ok[sel]) ? canvas[sel] : '0;
    end
    if (plot_en)
      canvas[prow] <= (row_ok[prow] ? canvas[prow] : '0) | (64'd1 << plx[5:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
    end else if (cmd.clr_step) begin
      row_ok[clr_row] <= 1'b0;
    end else if (plot_en) begin
      row_ok[prow] <= 1'b1;
    end
  end

`ifndef SYNTH
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.line_step && cmd.circ_step)) else $error("two steppers active");
  a_clr: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_step |=> !row_ok[$past(clr_row)]) else $error("row not cleared");
  a_plot: assert property (@(posedge clk) disable iff (rst)
    plot_en |=> row_ok[$past(prow)]) else $error("plotted row not valid");
`endif

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap shape rasterizer: draws shapes on a
// private canvas copy, predicts every result word and compares at the output.
// ----------------------------------------------------------------------------
class raster_scoreboard;
  bit [63:0] canvas [32];
  bit [63:0] want_bits [$];
  bit        want_rd [$];
  int        errors;
  int        checked;

  function void plot(int x, int y);
    if (x >= 0 && x < 64 && y >= 0 && y < 32) canvas[y][x] = 1'b1;
  endfunction

  function void draw_line(int x0, int y0, int x1, int y1);
    int dx, dy, sx, sy, err, e2;
    dx = x1 > x0 ? x1 - x0 : x0 - x1;
    dy = y1 > y0 ? y1 - y0 : y0 - y1;
    sx = x0 < x1 ? 1 : -1;
    sy = y0 < y1 ? 1 : -1;
    err = dx - dy;
    forever begin
      plot(x0, y0);
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 > -dy) begin err -= dy; x0 += sx; end
      if (e2 < dx) begin err += dx; y0 += sy; end
    end
  endfunction

  function void draw_circle(int xc, int yc, int r);
    int x, y, d;
    x = 0; y = r; d = 3 - 2 * r;
    while (y >= x) begin
      plot(xc + x, yc + y); plot(xc - x, yc + y);
      plot(xc + x, yc - y); plot(xc - x, yc - y);
      plot(xc + y, yc + x); plot(xc - y, yc + x);
      plot(xc + y, yc - x); plot(xc - y, yc - x);
      x++;
      if (d > 0) begin
        y--;
        d = d + 4 * (x - y) + 10;
      end else begin
        d = d + 4 * x + 6;
      end
    end
  endfunction

  function void note_request(bit [2:0] req, int ax, int ay, int bx, int by, int cx,
                             int cy, int w, int h, int r, int sel);
    bit [63:0] bits;
    bit        rd;
    bits = '0;
    rd = 1'b0;
    case (req)
      bsr_pkg::REQ_CLEAR: foreach (canvas[i]) canvas[i] = '0;
      bsr_pkg::REQ_LINE: draw_line(ax, ay, bx, by);
      bsr_pkg::REQ_RECT: begin
        draw_line(ax, ay, ax + w, ay);
        draw_line(ax, ay, ax, ay + h);
        draw_line(ax + w, ay, ax + w, ay + h);
        draw_line(ax, ay + h, ax + w, ay + h);
      end
      bsr_pkg::REQ_CIRCLE: draw_circle(ax, ay, r);
      bsr_pkg::REQ_TRI: begin
        draw_line(ax, ay, bx, by);
        draw_line(bx, by, cx, cy);
        draw_line(cx, cy, ax, ay);
      end
      bsr_pkg::REQ_READ: begin
        if (sel < 32) bits = canvas[sel];
        rd = 1'b1;
      end
      default: ;
    endcase
    want_bits.push_back(bits);
    want_rd.push_back(rd);
  endfunction

  function void check_word(bit [63:0] bits, bit rd);
    checked++;
    if (want_bits.size() == 0) begin
      $display("%0t: unexpected word bits=%h rd=%0b", $time, bits, rd);
      errors++;
      return;
    end
    if (want_bits[0] !== bits) begin
      $display("%0t: row_bits expected %h actual %h", $time, want_bits[0], bits);
      errors++;
    end
    if (want_rd[0] !== rd) begin
      $display("%0t: is_readback expected %0b actual %0b", $time, want_rd[0], rd);
      errors++;
    end
    void'(want_bits.pop_front());
    void'(want_rd.pop_front());
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] req_type = '0;
  logic signed [11:0] ax = '0, ay = '0, bx = '0, by = '0, cx = '0, cy = '0;
  logic signed [11:0] rect_width = '0, rect_height = '0;
  logic [10:0] radius = '0;
  logic [4:0] row_select = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] row_bits;
  logic is_readback;

  raster_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycle_count = 0;
  int sent = 0;

  always #1 clk = ~clk;

  bitmap_shape_rasterizer i_dut (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 64'd20000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_word(row_bits, is_readback);
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // Coordinates mostly near the canvas, sometimes anywhere in the field range.
  function automatic logic [11:0] pick_coord(int hi);
    if ($urandom_range(9) == 0) return 12'($urandom);
    return 12'($urandom_range(hi + 8) - 8);
  endfunction

  task automatic send_word(bit [2:0] req, int a_x, int a_y, int b_x, int b_y, int c_x,
                           int c_y, int w, int h, int r, int sel);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req; ax <= 12'(a_x); ay <= 12'(a_y); bx <= 12'(b_x); by <= 12'(b_y);
    cx <= 12'(c_x); cy <= 12'(c_y); rect_width <= 12'(w); rect_height <= 12'(h);
    radius <= 11'(r); row_select <= 5'(sel);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(req, $signed(12'(a_x)), $signed(12'(a_y)), $signed(12'(b_x)),
                       $signed(12'(b_y)), $signed(12'(c_x)), $signed(12'(c_y)),
                       $signed(12'(w)), $signed(12'(h)), int'(11'(r)), int'(5'(sel)));
    sent++;
  endtask

  task automatic read_all();
    for (int i = 0; i < 32; i++) send_word(bsr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, i);
  endtask

  task automatic random_word();
    bit [2:0] req;
    int k;
    k = $urandom_range(99);
    if (k < 4) req = bsr_pkg::REQ_CLEAR;
    else if (k < 22) req = bsr_pkg::REQ_LINE;
    else if (k < 36) req = bsr_pkg::REQ_RECT;
    else if (k < 48) req = bsr_pkg::REQ_CIRCLE;
    else if (k < 60) req = bsr_pkg::REQ_TRI;
    else if (k < 97) req = bsr_pkg::REQ_READ;
    else req = 3'($urandom_range(7, 6));
    send_word(req, pick_coord(63), pick_coord(31), pick_coord(63), pick_coord(31),
              pick_coord(63), pick_coord(31),
              $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(80) - 40),
              $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(40) - 20),
              $urandom_range(19) == 0 ? 11'($urandom) : 11'($urandom_range(40)),
              5'($urandom));
  endtask

  initial begin
    int waited;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: field extremes, every command, clipping, zero radius, unused codes.
    send_word(bsr_pkg::REQ_LINE, 0, 0, 63, 31, 0, 0, 0, 0, 0, 0);
    send_word(bsr_pkg::REQ_LINE, 12'h800, 12'h800, 12'h7ff, 12'h7ff, 0, 0, 0, 0, 0, 0);
    send_word(bsr_pkg::REQ_LINE, 70, 5, -10, 20, 0, 0, 0, 0, 0, 0);
    send_word(bsr_pkg::REQ_RECT, 12'h7ff, 12'h7ff, 0, 0, 0, 0, 12'h7ff, 12'h7ff, 0, 0);
    send_word(bsr_pkg::REQ_RECT, 40, 20, 0, 0, 0, 0, -30, -15, 0, 0);
    send_word(bsr_pkg::REQ_RECT, 12'h800, 12'h800, 0, 0, 0, 0, 12'h800, 12'h800, 0, 0);
    send_word(bsr_pkg::REQ_CIRCLE, 30, 15, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(bsr_pkg::REQ_CIRCLE, 20, 10, 0, 0, 0, 0, 0, 0, 12, 0);
    send_word(bsr_pkg::REQ_CIRCLE, 12'hfff, 12'hfff, 0, 0, 0, 0, 0, 0, 11'h7ff, 0);
    send_word(bsr_pkg::REQ_TRI, 2, 2, 60, 8, 25, 30, 0, 0, 0, 0);
    send_word(bsr_pkg::REQ_TRI, -5, 40, 70, -3, 12'h7ff, 12'h800, 0, 0, 0, 0);
    send_word(3'd6, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff,
              12'hfff, 11'h7ff, 5'h1f);
    send_word(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(bsr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(bsr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 31);
    send_word(bsr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 15);
    read_all();
    send_word(bsr_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(bsr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 15);
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 3 ? 21 : 68) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 21 : 68) : 0;
      for (int n = 0; n < 170; n++) random_word();
      read_all();
    end
    in_valid <= 1'b0;
    waited = 0;
    while (board.want_bits.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    $display("Sent %0d command words over four idle/stall phases; %0d result words checked.",
             sent, board.checked);
    $display("Covered lines, rectangles, circles, triangles, clears, reads, unused codes.");
    if (board.errors == 0 && board.want_bits.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
